// ===== design/mrt_pkg.sv =====
package mrt_pkg;

  // Default width of the arithmetic on the candidate and the witness.
  localparam int unsigned NumWidthDef = 32;

  // Width of the candidate and witness fields on the input channel.
  localparam int unsigned FieldWidth = 32;

  // Sequencer states of one trial.
  typedef enum logic [3:0] {
    StIdle,
    StCheck,
    StSplit,
    StRedWait,
    StExpChk,
    StExpMulWait,
    StExpSqrWait,
    StSqChk,
    StSqWait,
    StResult
  } mrt_state_e;

  // Status of the shared modular multiplier, as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } mrt_mul_stat_t;

endpackage

// ===== design/mrt_in_if.sv =====
interface mrt_in_if
  import mrt_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [FieldWidth-1:0] candidate;
  logic [FieldWidth-1:0] witness;
  logic                  last_trial;

  modport source (output valid, candidate, witness, last_trial, input ready);
  modport sink (input valid, candidate, witness, last_trial, output ready);
endinterface

// ===== design/mrt_out_if.sv =====
interface mrt_out_if;
  logic valid;
  logic ready;
  logic probable_prime;
  logic run_done;

  modport source (output valid, probable_prime, run_done, input ready);
  modport sink (input valid, probable_prime, run_done, output ready);
endinterface

// ===== design/mrt_modmul.sv =====
module mrt_modmul
  import mrt_pkg::*;
#(
  parameter int unsigned NumWidth = NumWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [NumWidth-1:0] op_a_i,
  input  logic [NumWidth-1:0] op_b_i,
  input  logic [NumWidth-1:0] modulus_i,
  output mrt_mul_stat_t       stat_o,
  output logic [NumWidth-1:0] result_o
);

  localparam int unsigned CntWidth = $clog2(NumWidth);

  // Interleaved shift-and-add reduction, most significant multiplier bit
  // first. Each bit has two steps: a doubling step and an add step, each
  // followed by one conditional subtraction of the modulus.
  logic [NumWidth-1:0] a_q, b_q, m_q, acc_q;
  logic [NumWidth-1:0] a_d, b_d, m_d, acc_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                phase_q, phase_d;
  logic                busy_q, busy_d;
  logic                done_q, done_d;

  logic [NumWidth:0] sum;
  logic [NumWidth:0] diff;
  logic [NumWidth:0] addend;

  always_comb begin
    addend = b_q[NumWidth-1] ? {1'b0, a_q} : '0;
    sum    = phase_q ? ({1'b0, acc_q} + addend) : {acc_q, 1'b0};
    diff   = sum - {1'b0, m_q};
  end

  always_comb begin
    a_d     = a_q;
    b_d     = b_q;
    m_d     = m_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    phase_d = phase_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (!busy_q) begin
      if (start_i) begin
        a_d     = op_a_i;
        b_d     = op_b_i;
        m_d     = modulus_i;
        acc_d   = '0;
        cnt_d   = CntWidth'(NumWidth - 1);
        phase_d = 1'b0;
        busy_d  = 1'b1;
      end
    end else begin
      acc_d   = diff[NumWidth] ? sum[NumWidth-1:0] : diff[NumWidth-1:0];
      phase_d = !phase_q;
      if (phase_q) begin
        b_d = {b_q[NumWidth-2:0], 1'b0};
        if (cnt_q == '0) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    m_q   <= m_d;
    acc_q <= acc_d;
    cnt_q <= cnt_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign result_o    = acc_q;

endmodule

// ===== design/miller_rabin_trial.sv =====
// Each trial runs a sequence of modular multiplications on the shared multiplier: one
// witness reduction, up to two per exponent bit and up to r-1 squarings, at most
// 2*NUM_WIDTH - 1 in all.
// Throughput: one trial at a time; the shared bit-serial modular multiplier sets the pace.
// Reset: rst_ni is asynchronous and active low; it clears the sequencer, the output
// valid and the sticky composite flag of the run.
module miller_rabin_trial
  import mrt_pkg::*;
#(
  parameter int unsigned NUM_WIDTH = NumWidthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  mrt_in_if.sink    trial_i,
  mrt_out_if.source verdict_o
);

  localparam int unsigned W  = NUM_WIDTH;
  localparam int unsigned RW = $clog2(NUM_WIDTH);

  // The sequencer walks one trial through these phases:
  //   check the small and even candidates, which need no arithmetic;
  //   split n-1 into 2^r * d by shifting out trailing zeros, one per cycle;
  //   reduce the witness mod n on the multiplier (1 times witness);
  //   raise it to d, right to left, with one multiply per set bit and one
  //   squaring per bit;
  //   square up to r-1 more times looking for n-1 or 1;
  //   hand the verdict to the output register and update the run flag.
  mrt_state_e state_q, state_d;

  logic [W-1:0]  n_q, n_d;
  logic [W-1:0]  wit_q, wit_d;
  logic          last_q, last_d;
  logic [W-1:0]  d_q, d_d;        // odd part, then the remaining exponent
  logic [RW-1:0] r_q, r_d;        // count of factors of two in n-1
  logic [RW-1:0] j_q, j_d;        // one plus the squarings done after the exponentiation
  logic [W-1:0]  acc_q, acc_d;    // running power, then the value being squared
  logic [W-1:0]  base_q, base_d;  // repeated squares of the reduced witness
  logic          pass_q, pass_d;  // verdict of the current trial
  logic          comp_q, comp_d;  // sticky composite flag of the run

  logic out_valid_q, out_valid_d;
  logic out_pp_q, out_pp_d;
  logic out_done_q, out_done_d;

  logic          in_xfer;
  logic          out_free;
  logic          fail_any;
  logic [W-1:0]  nm1;
  logic          n_trivial;
  logic          n_trivial_pass;
  logic          wit_trivial;
  logic          pow_trivial;

  // Shared multiplier hookup.
  logic          mul_start;
  logic [W-1:0]  mul_a;
  logic [W-1:0]  mul_b;
  logic [W-1:0]  mul_res;
  mrt_mul_stat_t mul_stat;

  mrt_modmul #(
    .NumWidth(W)
  ) u_modmul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .op_a_i   (mul_a),
    .op_b_i   (mul_b),
    .modulus_i(n_q),
    .stat_o   (mul_stat),
    .result_o (mul_res)
  );

  assign in_xfer  = trial_i.valid && trial_i.ready;
  // A result may wait in the output register while the next trial runs;
  // the new verdict is loaded when the register is empty or its result is taken.
  assign out_free = !out_valid_q || verdict_o.ready;
  assign nm1      = n_q - 1'b1;

  // Candidates decided without arithmetic: below two, two, three, or even.
  always_comb begin
    n_trivial      = 1'b1;
    n_trivial_pass = 1'b0;
    if (n_q < W'(2)) begin
      n_trivial_pass = 1'b0;
    end else if (n_q == W'(2) || n_q == W'(3)) begin
      n_trivial_pass = 1'b1;
    end else if (!n_q[0]) begin
      n_trivial_pass = 1'b0;
    end else begin
      n_trivial = 1'b0;
    end
  end

  assign wit_trivial = (mul_res == '0) || (mul_res == W'(1)) || (mul_res == nm1);
  assign pow_trivial = (acc_q == W'(1)) || (acc_q == nm1);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_xfer) state_d = StCheck;
      end
      StCheck: begin
        state_d = n_trivial ? StResult : StSplit;
      end
      StSplit: begin
        if (d_q[0]) state_d = StRedWait;
      end
      StRedWait: begin
        if (mul_stat.done) state_d = wit_trivial ? StResult : StExpChk;
      end
      StExpChk: begin
        if (d_q == '0) begin
          state_d = pow_trivial ? StResult : StSqChk;
        end else if (d_q[0]) begin
          state_d = StExpMulWait;
        end else begin
          state_d = StExpSqrWait;
        end
      end
      StExpMulWait: begin
        if (mul_stat.done) state_d = StExpSqrWait;
      end
      StExpSqrWait: begin
        if (mul_stat.done) state_d = StExpChk;
      end
      StSqChk: begin
        state_d = (j_q < r_q) ? StSqWait : StResult;
      end
      StSqWait: begin
        if (mul_stat.done) begin
          if (mul_res == nm1 || mul_res == W'(1)) begin
            state_d = StResult;
          end else begin
            state_d = StSqChk;
          end
        end
      end
      StResult: begin
        if (out_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Sequencer outputs: input ready and the multiplier's start and operands.
  always_comb begin
    trial_i.ready = 1'b0;
    mul_start     = 1'b0;
    mul_a         = acc_q;
    mul_b         = acc_q;
    case (state_q)
      StIdle: begin
        trial_i.ready = 1'b1;
      end
      StSplit: begin
        // Witness reduction: 1 times the witness, mod n.
        mul_start = d_q[0];
        mul_a     = W'(1);
        mul_b     = wit_q;
      end
      StExpChk: begin
        mul_start = (d_q != '0);
        mul_a     = d_q[0] ? acc_q : base_q;
        mul_b     = base_q;
      end
      StExpMulWait: begin
        mul_start = mul_stat.done;
        mul_a     = base_q;
        mul_b     = base_q;
      end
      StSqChk: begin
        mul_start = (j_q < r_q);
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  // Datapath registers of the trial.
  always_comb begin
    n_d    = n_q;
    wit_d  = wit_q;
    last_d = last_q;
    d_d    = d_q;
    r_d    = r_q;
    j_d    = j_q;
    acc_d  = acc_q;
    base_d = base_q;
    pass_d = pass_q;
    case (state_q)
      StIdle: begin
        if (in_xfer) begin
          n_d    = trial_i.candidate[W-1:0];
          wit_d  = trial_i.witness[W-1:0];
          last_d = trial_i.last_trial;
        end
      end
      StCheck: begin
        pass_d = n_trivial_pass;
        d_d    = nm1;
        r_d    = '0;
      end
      StSplit: begin
        if (!d_q[0]) begin
          d_d = d_q >> 1;
          r_d = r_q + 1'b1;
        end
      end
      StRedWait: begin
        if (mul_stat.done) begin
          pass_d = 1'b1;
          acc_d  = W'(1);
          base_d = mul_res;
        end
      end
      StExpChk: begin
        if (d_q == '0) begin
          pass_d = pow_trivial;
          j_d    = RW'(1);
        end
      end
      StExpMulWait: begin
        if (mul_stat.done) acc_d = mul_res;
      end
      StExpSqrWait: begin
        if (mul_stat.done) begin
          base_d = mul_res;
          d_d    = d_q >> 1;
        end
      end
      StSqChk: begin
        if (!(j_q < r_q)) pass_d = 1'b0;
      end
      StSqWait: begin
        if (mul_stat.done) begin
          acc_d  = mul_res;
          pass_d = (mul_res == nm1);
          j_d    = j_q + 1'b1;
        end
      end
      default: begin
        pass_d = pass_q;
      end
    endcase
  end

  // Verdict and the run's sticky flag, committed when the result is loaded.
  assign fail_any = comp_q || !pass_q;

  always_comb begin
    comp_d      = comp_q;
    out_valid_d = out_valid_q && !verdict_o.ready;
    out_pp_d    = out_pp_q;
    out_done_d  = out_done_q;
    if (state_q == StResult && out_free) begin
      out_valid_d = 1'b1;
      out_pp_d    = !fail_any;
      out_done_d  = last_q;
      comp_d      = last_q ? 1'b0 : fail_any;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      comp_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      comp_q      <= comp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    wit_q      <= wit_d;
    last_q     <= last_d;
    d_q        <= d_d;
    r_q        <= r_d;
    j_q        <= j_d;
    acc_q      <= acc_d;
    base_q     <= base_d;
    pass_q     <= pass_d;
    out_pp_q   <= out_pp_d;
    out_done_q <= out_done_d;
  end

  assign verdict_o.valid          = out_valid_q;
  assign verdict_o.probable_prime = out_pp_q;
  assign verdict_o.run_done       = out_done_q;

endmodule

// ===== design/mrt_checker.sv =====
module mrt_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_pp_i,
  input logic out_done_i
);

  logic       in_xfer;
  logic       out_xfer;
  logic [1:0] pending_q, pending_d;
  logic       fail_q, fail_d;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  // Trials taken but not yet answered, and the failure state of the run.
  always_comb begin
    pending_d = pending_q + {1'b0, in_xfer} - {1'b0, out_xfer};
    fail_d    = fail_q;
    if (out_xfer) fail_d = out_done_i ? 1'b0 : !out_pp_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
      fail_q    <= 1'b0;
    end else begin
      pending_q <= pending_d;
      fail_q    <= fail_d;
    end
  end

  // A result waiting for the sink stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // The block works on one trial at a time.
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_i)
    else $error("input ready right after a transfer");

  // A result never appears without a trial that caused it.
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pending_q != 2'd0)
    else $error("result without a pending trial");

  // At most one result waits while the next trial is taken.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> pending_q < 2'd2)
    else $error("trial taken with two outstanding");

  // Once a trial of the run failed, the run stays composite until its end.
  a_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && fail_q |-> !out_pp_i)
    else $error("composite verdict lost within a run");

endmodule

bind miller_rabin_trial mrt_checker u_mrt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (trial_i.valid),
  .in_ready_i (trial_i.ready),
  .out_valid_i(verdict_o.valid),
  .out_ready_i(verdict_o.ready),
  .out_pp_i   (verdict_o.probable_prime),
  .out_done_i (verdict_o.run_done)
);
